[rtl/core/assert_macros.svh]
// Assertion macros shared by the queue RTL.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

[rtl/core/spjq_pkg.sv]
// Package for the stable priority job queue: codes, FSM states, order compare.
// No dependencies.
package spjq_pkg;
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_REPRI = 2'd2;
  localparam logic [1:0] CMD_ERASE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SORT_RD, S_SORT_CMP, S_DONE
  } state_t;

  // order key compare: a goes ahead of b
  function automatic logic goes_before(input logic signed [31:0] pa, input logic [31:0] sa,
                                       input logic signed [31:0] pb, input logic [31:0] sb);
    goes_before = (pa != pb) ? (pa > pb) : (sa < sb);
  endfunction
endpackage

[rtl/core/spjq_store.sv]
// Job storage: one memory, one write and one registered read port.
// Uses nothing from spjq_pkg; widths are given by parameters.
module spjq_store #(
  parameter int DEPTH = 16,
  parameter int W     = 200,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/stable_priority_job_queue.sv]
// Channel  | ports                      | beat
// in       | in_tvalid/tready/tdata     | one command
// out      | out_tvalid/tready/tdata    | one result
// cfg      | cfg_we/cfg_wdata           | capacity write
// Each command (but a push when full or a pop when empty) walks the stored
// entries once through one compare unit: a compacting scan (read, compare,
// rewrite). Push writes the new job into the gap; a hit on reprioritize then
// runs an insertion sort.
// Reset clears the count and control, and sets the capacity to 16. in_tready
// is low while busy and while a result waits; out_tdata holds until taken.
// Uses spjq_pkg, spjq_store, assert_macros.svh.
`include "assert_macros.svh"
module stable_priority_job_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_BITS    = 48
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic in_tvalid,
  output logic in_tready,
  // cmd[1:0], key, generation, src_rev, wld_rev,
  // sequence_req, priority_req, stage, zero fill
  input  logic [((2+KEY_BITS+161)+7)/8*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status[1:0], out_key, out_generation, out_src_rev,
  // out_wld_rev, out_sequence, out_priority, out_stage,
  // erased_count, occupancy, free_slots, zero fill
  output logic [((2+KEY_BITS+176)+7)/8*8-1:0] out_tdata
);
  localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH+1);
  localparam int JW  = KEY_BITS + 161;
  localparam int OW  = ((2+KEY_BITS+176)+7)/8*8;
  localparam int KO  = 0;
  localparam int GO  = KEY_BITS;
  localparam int SRO = KEY_BITS+32;
  localparam int WRO = KEY_BITS+64;
  localparam int SQO = KEY_BITS+96;
  localparam int PRO = KEY_BITS+128;
  localparam int STO = KEY_BITS+160;

  // job record layout: key, gen, srev, wrev, seq, prio, stage
  logic [JW-1:0] inj_r;
  logic [1:0]    cmd_r;
  logic [4:0]    cap_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_r, rd_nxt, wr_r, wr_nxt, i_r, i_nxt, j_r, j_nxt;
  logic          ins_r, ins_nxt, hit_r, hit_nxt, phase_r, phase_nxt;
  logic [JW-1:0] tmp_r, tmp_nxt, pop_r, pop_nxt;
  logic [1:0]    status_r, status_nxt;
  spjq_pkg::state_t st_r, st_nxt;
  logic          ov_r;
  logic [OW-1:0] od_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [JW-1:0] wdata, rdata;
  logic [CW-1:0] raddr_w;

  spjq_store #(.DEPTH(QUEUE_DEPTH), .W(JW), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [5:0] capx;
  assign capx = (cap_r > QUEUE_DEPTH) ? 6'(QUEUE_DEPTH) : {1'b0, cap_r};
  assign in_tready = (st_r == spjq_pkg::S_IDLE) && !ov_r;

  // shared compare unit: stored entry against the incoming or held job
  logic [JW-1:0] ref_j;
  logic          before_w, keyeq, geneq;
  assign ref_j = (st_r == spjq_pkg::S_SORT_CMP) ? tmp_r : inj_r;
  assign before_w = spjq_pkg::goes_before(
      (st_r == spjq_pkg::S_SORT_CMP) ? tmp_r[PRO+:32] : rdata[PRO+:32],
      (st_r == spjq_pkg::S_SORT_CMP) ? tmp_r[SQO+:32] : rdata[SQO+:32],
      (st_r == spjq_pkg::S_SORT_CMP) ? rdata[PRO+:32] : inj_r[PRO+:32],
      (st_r == spjq_pkg::S_SORT_CMP) ? rdata[SQO+:32] : inj_r[SQO+:32]);
  assign keyeq = rdata[KO+:KEY_BITS] == ref_j[KO+:KEY_BITS];
  assign geneq = rdata[GO+:32] == ref_j[GO+:32];
  assign raddr = raddr_w[AW-1:0];

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      spjq_pkg::S_IDLE:
        if (in_tvalid && in_tready) st_nxt = spjq_pkg::S_SCAN;
      spjq_pkg::S_SCAN:
        if (phase_r && rd_r >= cnt_r)
          st_nxt = (cmd_r == spjq_pkg::CMD_REPRI && hit_r && cnt_r > 1) ?
                   spjq_pkg::S_SORT_RD : spjq_pkg::S_DONE;
      spjq_pkg::S_SORT_RD:
        st_nxt = (i_r >= cnt_r) ? spjq_pkg::S_DONE : spjq_pkg::S_SORT_CMP;
      spjq_pkg::S_SORT_CMP:
        st_nxt = spjq_pkg::S_SORT_RD;
      spjq_pkg::S_DONE:
        st_nxt = spjq_pkg::S_IDLE;
      default: st_nxt = spjq_pkg::S_IDLE;
    endcase
  end

  // datapath sequencing
  always_comb begin
    rd_nxt = rd_r; wr_nxt = wr_r; i_nxt = i_r; j_nxt = j_r;
    ins_nxt = ins_r; hit_nxt = hit_r; phase_nxt = phase_r;
    tmp_nxt = tmp_r; pop_nxt = pop_r; status_nxt = status_r; cnt_nxt = cnt_r;
    we = 1'b0; waddr = wr_r[AW-1:0]; wdata = rdata; raddr_w = rd_r;
    unique case (st_r)
      spjq_pkg::S_IDLE: begin
        rd_nxt = '0; wr_nxt = '0; ins_nxt = 1'b0; hit_nxt = 1'b0; phase_nxt = 1'b0;
        pop_nxt = '0; status_nxt = spjq_pkg::ST_OK;
        if (in_tvalid && in_tready) begin
          unique case (in_tdata[1:0])
            spjq_pkg::CMD_PUSH:
              if ({1'b0, cnt_r} >= capx || cnt_r >= CW'(QUEUE_DEPTH))
                status_nxt = spjq_pkg::ST_FULL;
            spjq_pkg::CMD_POP:
              if (cnt_r == '0) status_nxt = spjq_pkg::ST_EMPTY;
            default: ;
          endcase
        end
      end
      spjq_pkg::S_SCAN: begin
        // phase 0 issues read of rd_r; phase 1 uses the data
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          if (rd_r < cnt_r) begin
            unique case (cmd_r)
              spjq_pkg::CMD_PUSH:
                if (status_r == spjq_pkg::ST_OK) begin
                  if (!ins_r && !before_w) begin
                    // new job goes here; displaced entry is held
                    we = 1'b1; wdata = inj_r; ins_nxt = 1'b1;
                    tmp_nxt = rdata; wr_nxt = wr_r + 1'b1; rd_nxt = rd_r + 1'b1;
                  end else if (ins_r) begin
                    // ripple held entry one slot down
                    we = 1'b1; wdata = tmp_r; tmp_nxt = rdata;
                    wr_nxt = wr_r + 1'b1; rd_nxt = rd_r + 1'b1;
                  end else begin
                    wr_nxt = wr_r + 1'b1; rd_nxt = rd_r + 1'b1;
                  end
                end else rd_nxt = cnt_r;
              spjq_pkg::CMD_POP:
                if (status_r == spjq_pkg::ST_OK) begin
                  if (rd_r == '0) pop_nxt = rdata;
                  else begin we = 1'b1; waddr = AW'(rd_r - 1'b1); end
                  rd_nxt = rd_r + 1'b1;
                end else rd_nxt = cnt_r;
              spjq_pkg::CMD_REPRI: begin
                if (keyeq && geneq) begin
                  we = 1'b1; waddr = rd_r[AW-1:0];
                  wdata = {rdata[JW-1:PRO+32], inj_r[PRO+:32], rdata[PRO-1:0]};
                  hit_nxt = 1'b1;
                end
                rd_nxt = rd_r + 1'b1;
              end
              default: begin
                if (!keyeq) begin
                  we = 1'b1; wr_nxt = wr_r + 1'b1;
                end
                rd_nxt = rd_r + 1'b1;
              end
            endcase
          end else begin
            // end of scan: close out per command
            unique case (cmd_r)
              spjq_pkg::CMD_PUSH:
                if (status_r == spjq_pkg::ST_OK) begin
                  we = 1'b1; wdata = ins_r ? tmp_r : inj_r;
                  cnt_nxt = cnt_r + 1'b1;
                end
              spjq_pkg::CMD_POP:
                if (status_r == spjq_pkg::ST_OK) cnt_nxt = cnt_r - 1'b1;
              spjq_pkg::CMD_REPRI:
                if (!hit_r) status_nxt = spjq_pkg::ST_NOMATCH;
              default: cnt_nxt = wr_r;
            endcase
            i_nxt = CW'(1); j_nxt = CW'(1); raddr_w = CW'(1);
          end
        end
      end
      spjq_pkg::S_SORT_RD: begin
        // j==i: load the held entry; else read slot j-1 for compare
        raddr_w = j_r - 1'b1;
        if (j_r == i_r) tmp_nxt = rdata;
      end
      spjq_pkg::S_SORT_CMP: begin
        // j at zero or held entry not ahead: place it at slot j
        if (j_r != '0 && before_w) begin
          we = 1'b1; waddr = j_r[AW-1:0]; wdata = rdata;
          j_nxt = j_r - 1'b1;
          raddr_w = j_r - 2'd2;
        end else begin
          we = 1'b1; waddr = j_r[AW-1:0]; wdata = tmp_r;
          i_nxt = i_r + 1'b1; j_nxt = i_r + 1'b1; raddr_w = i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic [5:0] freec;
  assign freec = (capx > {1'b0, cnt_r}) ? (capx - 6'(cnt_r)) : 6'd0;

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= spjq_pkg::S_IDLE; cnt_r <= '0; cap_r <= 5'd16; ov_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      if (st_r == spjq_pkg::S_DONE) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    rd_r <= rd_nxt; wr_r <= wr_nxt; ins_r <= ins_nxt; hit_r <= hit_nxt;
    phase_r <= phase_nxt; tmp_r <= tmp_nxt; pop_r <= pop_nxt;
    status_r <= status_nxt; i_r <= i_nxt; j_r <= j_nxt;
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tdata[1:0]; inj_r <= in_tdata[2+:JW];
    end
    // erase count: scan end pointer (old count) minus compacted count
    if (st_r == spjq_pkg::S_DONE)
      od_r <= OW'({5'(freec), 5'(cnt_r),
                   5'((cmd_r == spjq_pkg::CMD_ERASE) ? (rd_r - cnt_r) : '0),
                   pop_r, status_r});
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  `ASSERT_NEXT(a_busy_not_ready, clk, rst_n, st_r != spjq_pkg::S_IDLE, !in_tready || st_r == spjq_pkg::S_IDLE)
  `ASSERT_IMPL(a_cnt_bound, clk, rst_n, cnt_r <= CW'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_done_valid, clk, rst_n, st_r == spjq_pkg::S_DONE, out_tvalid)
endmodule
